FILE: src/rpc_pkg.sv
`default_nettype none

package rpc_pkg;

  // Table and pool dimensions
  localparam int unsigned SLOT_COUNT   = 32;
  localparam int unsigned BUFFER_COUNT = 8;
  localparam int unsigned BUFFER_BYTES = 256;

  // Field widths of the request and response channels
  localparam int unsigned CmdW    = 3;
  localparam int unsigned SeqW    = 8;
  localparam int unsigned LenInW  = 10;
  localparam int unsigned OffW    = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LenW    = 9;
  localparam int unsigned CntW    = 6;

  // Derived widths
  localparam int unsigned SlotW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned BufW    = 4;
  localparam int unsigned BufIdxW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int unsigned MemDepth = BUFFER_COUNT * BUFFER_BYTES;
  localparam int unsigned AddrW   = $clog2(MemDepth);
  localparam int unsigned CmpW    = 11;

  localparam logic [BufW-1:0] NO_BUFFER = 4'hF;

  typedef enum logic [CmdW-1:0] {
    CmdInsert = 3'd0,
    CmdWrite  = 3'd1,
    CmdFree   = 3'd2,
    CmdRead   = 3'd3,
    CmdClear  = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 3'd0,
    StIgnored   = 3'd1,
    StTooLarge  = 3'd2,
    StExhausted = 3'd3,
    StMiss      = 3'd4
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [SeqW-1:0]   seq;
    logic [LenInW-1:0] length;
    logic [OffW-1:0]   offset;
    logic [ByteW-1:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               hit;
    logic [LenW-1:0]    length_out;
    logic               data_sel;
    logic               slot_used;
    logic [CntW-1:0]    pending_total;
    logic               has_room;
  } result_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] wdata;
  } mem_op_t;

endpackage

`default_nettype wire

FILE: src/rpc_req_if.sv
`default_nettype none

interface rpc_req_if;
  logic                         valid;
  logic                         ready;
  logic [rpc_pkg::CmdW-1:0]     cmd;
  logic [rpc_pkg::SeqW-1:0]     seq;
  logic [rpc_pkg::LenInW-1:0]   length;
  logic [rpc_pkg::OffW-1:0]     offset;
  logic [rpc_pkg::ByteW-1:0]    data_byte;

  modport source (output valid, cmd, seq, length, offset, data_byte, input ready);
  modport sink   (input valid, cmd, seq, length, offset, data_byte, output ready);
endinterface

`default_nettype wire

FILE: src/rpc_rsp_if.sv
`default_nettype none

interface rpc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rpc_pkg::StatusW-1:0]   status;
  logic                          hit;
  logic [rpc_pkg::LenW-1:0]      length_out;
  logic [rpc_pkg::ByteW-1:0]     data_out;
  logic                          slot_used;
  logic [rpc_pkg::CntW-1:0]      pending_total;
  logic                          has_room;

  modport source (output valid, status, hit, length_out, data_out, slot_used,
                  pending_total, has_room, input ready);
  modport sink   (input valid, status, hit, length_out, data_out, slot_used,
                  pending_total, has_room, output ready);
endinterface

`default_nettype wire

FILE: src/retransmit_payload_cache.sv
// Retransmission payload cache: a table of SLOT_COUNT slots addressed by
// sequence number, backed by BUFFER_COUNT payload buffers of BUFFER_BYTES
// bytes kept in a single-port RAM. Each request (insert, write byte, free,
// read, clear all) gives exactly one response carrying status, read hit,
// length, one payload byte, slot-in-use, the count of slots in use and the
// has-room flag. One request is taken every clock cycle while the response
// is not stalled; a request waits in the input register, where the slot
// table in flip-flops is looked up and updated and the payload RAM is
// accessed at most once, and its response is shown from the result register
// in the cycle after its commit. The read byte comes straight from the
// RAM's registered output next to the result register. Clear all empties
// the whole table in a single update; payload bytes are never cleared, and
// a byte that was never written reads as whatever the RAM holds.

`default_nettype none

module retransmit_payload_cache (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpc_req_if.sink    req_i,
  rpc_rsp_if.source  rsp_o
);

  logic             s1_valid_q;
  rpc_pkg::item_t   s1_item_q;
  logic             s2_valid_q;
  rpc_pkg::result_t s2_res_q;

  rpc_pkg::result_t res;
  rpc_pkg::mem_op_t mem_op;
  logic [rpc_pkg::ByteW-1:0] ram_rdata;

  logic s2_free;
  logic commit;

  // Advance the result stage when it is empty or being drained; commit the
  // request held in the input register at the same edge.
  assign s2_free     = !s2_valid_q || rsp_o.ready;
  assign commit      = s1_valid_q && s2_free;
  assign req_i.ready = !s1_valid_q || commit;

  // Input register: hold the request until its table update commits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_item_q.cmd       <= req_i.cmd;
      s1_item_q.seq       <= req_i.seq;
      s1_item_q.length    <= req_i.length;
      s1_item_q.offset    <= req_i.offset;
      s1_item_q.data_byte <= req_i.data_byte;
    end
  end

  rpc_slot_table u_slot_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .item_i   (s1_item_q),
    .res_o    (res),
    .mem_o    (mem_op)
  );

  // Payload RAM: the read data register stays put while the response stalls,
  // since reads are only issued on commit.
  rpc_payload_ram #(
    .DataW (rpc_pkg::ByteW),
    .Depth (rpc_pkg::MemDepth),
    .AddrW (rpc_pkg::AddrW)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .en_i    (mem_op.en),
    .we_i    (mem_op.we),
    .addr_i  (mem_op.addr),
    .wdata_i (mem_op.wdata),
    .rdata_o (ram_rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      s2_res_q <= res;
    end
  end

  assign rsp_o.valid         = s2_valid_q;
  assign rsp_o.status        = s2_res_q.status;
  assign rsp_o.hit           = s2_res_q.hit;
  assign rsp_o.length_out    = s2_res_q.length_out;
  assign rsp_o.data_out      = s2_res_q.data_sel ? ram_rdata : '0;
  assign rsp_o.slot_used     = s2_res_q.slot_used;
  assign rsp_o.pending_total = s2_res_q.pending_total;
  assign rsp_o.has_room      = s2_res_q.has_room;

endmodule

`default_nettype wire

FILE: src/rpc_payload_ram.sv
`default_nettype none

module rpc_payload_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/rpc_slot_table.sv
`default_nettype none

module rpc_slot_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             commit_i,
  input  rpc_pkg::item_t   item_i,
  output rpc_pkg::result_t res_o,
  output rpc_pkg::mem_op_t mem_o
);

  logic [rpc_pkg::SLOT_COUNT-1:0]   valid_q, valid_d;
  logic [rpc_pkg::BufW-1:0]         buf_q [rpc_pkg::SLOT_COUNT];
  logic [rpc_pkg::BufW-1:0]         buf_d [rpc_pkg::SLOT_COUNT];
  logic [rpc_pkg::LenW-1:0]         len_q [rpc_pkg::SLOT_COUNT];
  logic [rpc_pkg::LenW-1:0]         len_d [rpc_pkg::SLOT_COUNT];
  logic [rpc_pkg::BUFFER_COUNT-1:0] busy_q, busy_d, busy_rel;
  logic [rpc_pkg::CntW-1:0]         cnt_q, cnt_d, cnt_rel;

  logic [rpc_pkg::SlotW-1:0]   idx;
  logic                        in_range;
  logic                        cur_valid;
  logic [rpc_pkg::BufW-1:0]    cur_buf;
  logic [rpc_pkg::LenW-1:0]    cur_len;
  logic                        cur_has_buf;
  logic                        off_ok;
  logic [rpc_pkg::BufIdxW-1:0] pick;
  logic                        found;
  logic [rpc_pkg::AddrW-1:0]   addr;

  assign idx       = item_i.seq[rpc_pkg::SlotW-1:0];
  assign in_range  = rpc_pkg::CmpW'(item_i.seq) < rpc_pkg::CmpW'(rpc_pkg::SLOT_COUNT);
  assign cur_valid = valid_q[idx];
  assign cur_buf   = buf_q[idx];
  assign cur_len   = len_q[idx];
  assign cur_has_buf = rpc_pkg::CmpW'(cur_buf) < rpc_pkg::CmpW'(rpc_pkg::BUFFER_COUNT);
  assign off_ok    = (rpc_pkg::LenW'(item_i.offset) < cur_len) &&
                     (rpc_pkg::CmpW'(item_i.offset) < rpc_pkg::CmpW'(rpc_pkg::BUFFER_BYTES));
  assign addr      = rpc_pkg::AddrW'(cur_buf[rpc_pkg::BufIdxW-1:0]) *
                     rpc_pkg::AddrW'(rpc_pkg::BUFFER_BYTES) +
                     rpc_pkg::AddrW'(item_i.offset);

  // Release whatever the addressed slot holds.
  always_comb begin
    busy_rel = busy_q;
    if (cur_valid && cur_has_buf) begin
      busy_rel[cur_buf[rpc_pkg::BufIdxW-1:0]] = 1'b0;
    end
    cnt_rel = (cur_valid && cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
  end

  // Lowest free buffer after release.
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = rpc_pkg::BUFFER_COUNT - 1; i >= 0; i--) begin
      if (!busy_rel[i]) begin
        pick  = rpc_pkg::BufIdxW'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    buf_d   = buf_q;
    len_d   = len_q;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    res_o   = '0;
    res_o.status = rpc_pkg::StOk;
    mem_o   = '0;
    mem_o.addr  = addr;
    mem_o.wdata = item_i.data_byte;

    if (item_i.cmd == rpc_pkg::CmdClear) begin
      valid_d = '0;
      for (int s = 0; s < rpc_pkg::SLOT_COUNT; s++) begin
        buf_d[s] = rpc_pkg::NO_BUFFER;
        len_d[s] = '0;
      end
      busy_d = '0;
      cnt_d  = '0;
    end else if (!in_range) begin
      res_o.status = rpc_pkg::StIgnored;
    end else begin
      unique case (item_i.cmd)
        rpc_pkg::CmdInsert, rpc_pkg::CmdFree: begin
          valid_d[idx] = 1'b0;
          buf_d[idx]   = rpc_pkg::NO_BUFFER;
          len_d[idx]   = '0;
          busy_d       = busy_rel;
          cnt_d        = cnt_rel;
          if (item_i.cmd == rpc_pkg::CmdInsert) begin
            if (item_i.length == '0) begin
              valid_d[idx] = 1'b1;
              cnt_d        = cnt_rel + 1'b1;
            end else if (rpc_pkg::CmpW'(item_i.length) >
                         rpc_pkg::CmpW'(rpc_pkg::BUFFER_BYTES)) begin
              res_o.status = rpc_pkg::StTooLarge;
            end else if (!found) begin
              res_o.status = rpc_pkg::StExhausted;
            end else begin
              busy_d[pick] = 1'b1;
              valid_d[idx] = 1'b1;
              buf_d[idx]   = rpc_pkg::BufW'(pick);
              len_d[idx]   = rpc_pkg::LenW'(item_i.length);
              cnt_d        = cnt_rel + 1'b1;
            end
          end
        end
        rpc_pkg::CmdWrite: begin
          if (cur_valid && cur_has_buf && off_ok) begin
            mem_o.en = 1'b1;
            mem_o.we = 1'b1;
          end else begin
            res_o.status = rpc_pkg::StMiss;
          end
        end
        rpc_pkg::CmdRead: begin
          if (cur_valid && cur_has_buf && cur_len != '0) begin
            res_o.hit        = 1'b1;
            res_o.length_out = cur_len;
            if (off_ok) begin
              mem_o.en       = 1'b1;
              res_o.data_sel = 1'b1;
            end
          end else begin
            res_o.status = rpc_pkg::StMiss;
          end
        end
        default: begin
          res_o.status = rpc_pkg::StIgnored;
        end
      endcase
    end

    res_o.slot_used     = (item_i.cmd != rpc_pkg::CmdClear) && in_range && valid_d[idx];
    res_o.pending_total = cnt_d;
    res_o.has_room      = (rpc_pkg::CmpW'(cnt_d) < rpc_pkg::CmpW'(rpc_pkg::SLOT_COUNT)) &&
                          !(&busy_d);
    mem_o.en = mem_o.en && commit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int s = 0; s < rpc_pkg::SLOT_COUNT; s++) begin
        buf_q[s] <= rpc_pkg::NO_BUFFER;
        len_q[s] <= '0;
      end
      busy_q <= '0;
      cnt_q  <= '0;
    end else if (commit_i) begin
      valid_q <= valid_d;
      buf_q   <= buf_d;
      len_q   <= len_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire
